// ----- hw/rtl/slh_pkg.sv -----
package slh_pkg;

  localparam int unsigned GUARD_BITS = 24;
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned LEN_W      = 34;
  localparam int unsigned HEAD_W     = 25;
  localparam int unsigned Z_W        = 42;

  localparam logic [31:0]       INV_GAIN         = 32'd2608131496;
  localparam logic [63:0]       DEG_FROM_RAD_Q26 = 64'd3845054675;
  localparam logic [63:0]       LEN_MAX          = (64'd1 << LEN_W) - 64'd1;
  localparam logic [Z_W-1:0]    Z_HALF_TURN      = Z_W'(180) << 32;
  localparam logic [Z_W-1:0]    Z_FULL_TURN      = Z_W'(360) << 32;
  localparam logic [HEAD_W:0]   HEAD_FULL_TURN   = (HEAD_W + 1)'(360) << 16;

  typedef struct packed {
    logic           zero;
    logic [Z_W-1:0] z;
  } slh_tag_t;

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctangent of 2^-step in degrees Q.32
  function automatic logic [63:0] atan_deg_q32(input int unsigned step);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] odd;
    logic [63:0] rad32;
    int unsigned e;
    if (step == 0) begin
      return 64'd45 << 32;
    end
    sum = '0;
    for (int unsigned k = 0; k < 32; k++) begin
      odd = 64'(2 * k + 1);
      e   = step * (2 * k + 1);
      if (e <= 62) begin
        term = udiv64(64'd1 << (62 - e), odd);
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    rad32 = (sum + (64'd1 << 29)) >> 30;
    return (rad32 * DEG_FROM_RAD_Q26 + (64'd1 << 25)) >> 26;
  endfunction

endpackage

// ----- hw/rtl/slh_prep.sv -----
module slh_prep #(
  parameter int unsigned CU = 32,
  parameter int unsigned XW = 59
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [slh_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output logic signed [XW-1:0]           dn_x,
  output logic signed [XW-1:0]           dn_y,
  output slh_pkg::slh_tag_t              dn_tag
);

  localparam int unsigned FW = slh_pkg::FIELD_W;

  logic [CU:0]           sx, sy, ex, ey;
  logic [CU:0]           dxp, dxn, dyp, dyn, xsel, ysel;
  logic                  neg;
  logic                  valid_r;
  logic signed [XW-1:0]  x_r, y_r, x_nxt, y_nxt;
  slh_pkg::slh_tag_t     tag_r, tag_nxt;

  always_comb begin
    sx   = {in_tdata[CU-1], in_tdata[CU-1:0]};
    sy   = {in_tdata[FW+CU-1], in_tdata[FW+CU-1:FW]};
    ex   = {in_tdata[2*FW+CU-1], in_tdata[2*FW+CU-1:2*FW]};
    ey   = {in_tdata[3*FW+CU-1], in_tdata[3*FW+CU-1:3*FW]};
    dxp  = ex - sx;
    dxn  = sx - ex;
    dyp  = ey - sy;
    dyn  = sy - ey;
    neg  = dxp[CU];
    xsel = neg ? dxn : dxp;
    ysel = neg ? dyn : dyp;
    x_nxt = {{2{xsel[CU]}}, xsel, {slh_pkg::GUARD_BITS{1'b0}}};
    y_nxt = {{2{ysel[CU]}}, ysel, {slh_pkg::GUARD_BITS{1'b0}}};
    tag_nxt.zero = (dxp == '0) && (dyp == '0);
    tag_nxt.z    = neg ? slh_pkg::Z_HALF_TURN : '0;
  end

  assign in_tready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      tag_r <= tag_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_x     = x_r;
  assign dn_y     = y_r;
  assign dn_tag   = tag_r;

endmodule

// ----- hw/rtl/slh_cell.sv -----
module slh_cell #(
  parameter int unsigned STEP = 0,
  parameter int unsigned XW   = 59
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic signed [XW-1:0]  up_x,
  input  logic signed [XW-1:0]  up_y,
  input  slh_pkg::slh_tag_t     up_tag,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic signed [XW-1:0]  dn_x,
  output logic signed [XW-1:0]  dn_y,
  output slh_pkg::slh_tag_t     dn_tag
);

  localparam logic [63:0]             ANGLE   = slh_pkg::atan_deg_q32(STEP);
  localparam logic [slh_pkg::Z_W-1:0] ANGLE_Z = ANGLE[slh_pkg::Z_W-1:0];

  logic                  valid_r;
  logic signed [XW-1:0]  xs, ys;
  logic signed [XW-1:0]  x_r, y_r, x_nxt, y_nxt;
  slh_pkg::slh_tag_t     tag_r, tag_nxt;

  always_comb begin
    xs           = up_x >>> STEP;
    ys           = up_y >>> STEP;
    tag_nxt.zero = up_tag.zero;
    if (!up_y[XW-1]) begin
      x_nxt     = up_x + ys;
      y_nxt     = up_y - xs;
      tag_nxt.z = up_tag.z + ANGLE_Z;
    end else begin
      x_nxt     = up_x - ys;
      y_nxt     = up_y + xs;
      tag_nxt.z = up_tag.z - ANGLE_Z;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      tag_r <= tag_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_x     = x_r;
  assign dn_y     = y_r;
  assign dn_tag   = tag_r;

endmodule

// ----- hw/rtl/slh_post.sv -----
module slh_post #(
  parameter int unsigned XW = 59
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic signed [XW-1:0]           up_x,
  input  slh_pkg::slh_tag_t              up_tag,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [slh_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser
);

  localparam int unsigned HI_W = XW - 33;
  localparam int unsigned ZW   = slh_pkg::Z_W;
  localparam int unsigned LW   = slh_pkg::LEN_W;
  localparam int unsigned HW   = slh_pkg::HEAD_W;

  logic [XW-2:0]         xm;
  logic [HI_W+31:0]      hi_r, hi_nxt;
  logic [63:0]           lo_r, lo_nxt;
  logic [ZW-1:0]         zp, zm, zsel;
  logic [ZW-2:0]         zw_r;
  logic                  zero_r;
  logic                  mid_valid_r;
  logic                  mid_ready;

  logic [63:0]           sum, rsh;
  logic [LW-1:0]         len;
  logic [HW:0]           hr;
  logic [HW-1:0]         head;
  logic                  out_valid_r;
  logic [LW-1:0]         len_r;
  logic [HW-1:0]         head_r;
  logic                  zflag_r;

  always_comb begin
    xm     = up_x[XW-1] ? '0 : up_x[XW-2:0];
    hi_nxt = (HI_W + 32)'(xm[XW-2:32]) * (HI_W + 32)'(slh_pkg::INV_GAIN);
    lo_nxt = 64'(xm[31:0]) * 64'(slh_pkg::INV_GAIN);
    zp     = up_tag.z + slh_pkg::Z_FULL_TURN;
    zm     = up_tag.z - slh_pkg::Z_FULL_TURN;
    if (up_tag.z[ZW-1]) begin
      zsel = zp;
    end else if (up_tag.z >= slh_pkg::Z_FULL_TURN) begin
      zsel = zm;
    end else begin
      zsel = up_tag.z;
    end
  end

  assign mid_ready = !out_valid_r || out_tready;
  assign up_ready  = !mid_valid_r || mid_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else if (up_ready) begin
      mid_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      hi_r   <= hi_nxt;
      lo_r   <= lo_nxt;
      zw_r   <= zsel[ZW-2:0];
      zero_r <= up_tag.zero;
    end
  end

  always_comb begin
    sum  = 64'(hi_r) + 64'(lo_r[63:32]) + (64'd1 << 23);
    rsh  = sum >> 24;
    len  = (rsh > slh_pkg::LEN_MAX) ? slh_pkg::LEN_MAX[LW-1:0] : rsh[LW-1:0];
    hr   = (HW + 1)'((ZW'(zw_r) + ZW'(32768)) >> 16);
    head = (hr >= slh_pkg::HEAD_FULL_TURN) ? HW'(hr - slh_pkg::HEAD_FULL_TURN) : hr[HW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mid_ready) begin
      out_valid_r <= mid_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && mid_valid_r) begin
      len_r   <= zero_r ? '0 : len;
      head_r  <= zero_r ? '0 : head;
      zflag_r <= zero_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(slh_pkg::OUT_DATA_W - LW - HW){1'b0}}, head_r, len_r};
  assign out_tuser  = zflag_r;

endmodule

// ----- hw/rtl/segment_length_and_heading_unit.sv -----
// channel | dir | word
// in_     | in  | tdata: start_x, start_y, end_x, end_y (32 bits each, signed Q16.16)
// out_    | out | tdata: seg_length (34), heading_deg (25); tuser: zero_length
//
// One word per cycle in and out while out_tready is held high; the pipeline
// has one setup stage, one rotation cell per step and two scaling stages.
// Reset clears only the valid flags of the stages.
// Each stage holds while the next one is full and stalled; empty stages
// keep filling, so the input stays open while a result waits.
module segment_length_and_heading_unit #(
  parameter int unsigned ROTATION_STEPS = 24,
  parameter int unsigned COORD_BITS     = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // start_x [31:0], start_y [63:32], end_x [95:64], end_y [127:96]
  input  logic [slh_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // seg_length [33:0], heading_deg [58:34], zero [63:59]
  output logic [slh_pkg::OUT_DATA_W-1:0] out_tdata,
  // zero_length [0]
  output logic                           out_tuser
);

  localparam int unsigned CU = (COORD_BITS < slh_pkg::FIELD_W) ? COORD_BITS : slh_pkg::FIELD_W;
  localparam int unsigned XW = CU + 3 + slh_pkg::GUARD_BITS;

  logic                  chain_valid [0:ROTATION_STEPS];
  logic                  chain_ready [0:ROTATION_STEPS];
  logic signed [XW-1:0]  chain_x     [0:ROTATION_STEPS];
  logic signed [XW-1:0]  chain_y     [0:ROTATION_STEPS];
  slh_pkg::slh_tag_t     chain_tag   [0:ROTATION_STEPS];

  slh_prep #(
    .CU (CU),
    .XW (XW)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .dn_valid  (chain_valid[0]),
    .dn_ready  (chain_ready[0]),
    .dn_x      (chain_x[0]),
    .dn_y      (chain_y[0]),
    .dn_tag    (chain_tag[0])
  );

  for (genvar k = 0; k < ROTATION_STEPS; k++) begin : g_cell
    slh_cell #(
      .STEP (k),
      .XW   (XW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[k]),
      .up_ready (chain_ready[k]),
      .up_x     (chain_x[k]),
      .up_y     (chain_y[k]),
      .up_tag   (chain_tag[k]),
      .dn_valid (chain_valid[k+1]),
      .dn_ready (chain_ready[k+1]),
      .dn_x     (chain_x[k+1]),
      .dn_y     (chain_y[k+1]),
      .dn_tag   (chain_tag[k+1])
    );
  end

  slh_post #(
    .XW (XW)
  ) u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (chain_valid[ROTATION_STEPS]),
    .up_ready   (chain_ready[ROTATION_STEPS]),
    .up_x       (chain_x[ROTATION_STEPS]),
    .up_tag     (chain_tag[ROTATION_STEPS]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- test/tb_segment_length_and_heading_unit.sv -----
module tb_segment_length_and_heading_unit;

  localparam int unsigned STEPS = 24;
  localparam int unsigned LEN_W = slh_pkg::LEN_W;
  localparam int unsigned HEAD_W = slh_pkg::HEAD_W;
  localparam longint TURN_Q32 = 64'sd360 << 32;
  localparam longint HALF_TURN_Q32 = 64'sd180 << 32;
  localparam longint unsigned TURN_Q16 = 64'd360 << 16;

  typedef struct packed {
    logic              zero;
    logic [HEAD_W-1:0] heading;
    logic [LEN_W-1:0]  len;
  } seg_result_t;

  typedef struct packed {
    logic [slh_pkg::IN_DATA_W-1:0] word;
    seg_result_t                   want;
  } stim_row_t;

  typedef enum int unsigned {
    SHAPE_WIDE, SHAPE_SHORT, SHAPE_POINT, SHAPE_AXIS, SHAPE_SCALED, SHAPE_CORNER
  } seg_shape_t;

  localparam seg_result_t POINT_RESULT = {1'b1, {(HEAD_W + LEN_W){1'b0}}};

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [slh_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [slh_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                          out_tuser;

  seg_result_t offer_want = '0;
  seg_result_t heading_len_q[$];
  stim_row_t   directed_q[$];
  longint      atan_deg[32];
  logic [31:0] corner_vals [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                   32'hffff_ffff, 32'h0000_0001, 32'h0001_0000};
  int          errors = 0;
  int          sent = 0;
  bit          calm = 1'b0;
  bit          held = 1'b0;

  segment_length_and_heading_unit #(
    .ROTATION_STEPS(STEPS),
    .COORD_BITS(32)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned arctan_deg_q32(input int unsigned step);
    longint unsigned acc;
    longint unsigned term;
    longint unsigned rad;
    int unsigned k;
    int unsigned e;
    if (step == 0) begin
      return 64'd45 << 32;
    end
    acc = 0;
    k = 0;
    e = step;
    while (e <= 62) begin
      term = (64'd1 << (62 - e)) / longint'(2 * k + 1);
      if (k[0]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
      k++;
      e = step * (2 * k + 1);
    end
    rad = (acc + (64'd1 << 29)) >> 30;
    return (rad * slh_pkg::DEG_FROM_RAD_Q26 + (64'd1 << 25)) >> 26;
  endfunction

  function automatic seg_result_t predict_segment(input logic [slh_pkg::IN_DATA_W-1:0] w);
    seg_result_t r;
    longint dx, dy, cx, cy, ang, sx, sy;
    longint unsigned head, mag, hi, lo;
    r = '0;
    dx = $signed(w[95:64]) - $signed(w[31:0]);
    dy = $signed(w[127:96]) - $signed(w[63:32]);
    if (dx == 0 && dy == 0) begin
      r.zero = 1'b1;
      return r;
    end
    cx = dx <<< slh_pkg::GUARD_BITS;
    cy = dy <<< slh_pkg::GUARD_BITS;
    ang = 0;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      ang = HALF_TURN_Q32;
    end
    for (int i = 0; i < STEPS; i++) begin
      sx = cx >>> i;
      sy = cy >>> i;
      if (cy >= 0) begin
        cx = cx + sy;
        cy = cy - sx;
        ang = ang + atan_deg[i];
      end else begin
        cx = cx - sy;
        cy = cy + sx;
        ang = ang - atan_deg[i];
      end
    end
    if (ang < 0) begin
      ang = ang + TURN_Q32;
    end
    if (ang >= TURN_Q32) begin
      ang = ang - TURN_Q32;
    end
    head = ang;
    head = (head + 64'd32768) >> 16;
    if (head >= TURN_Q16) begin
      head = head - TURN_Q16;
    end
    mag = 0;
    if (cx > 0) begin
      mag = cx;
      hi = (mag >> 32) * slh_pkg::INV_GAIN;
      lo = (mag & 64'hffff_ffff) * slh_pkg::INV_GAIN;
      mag = (hi + (lo >> 32) + (64'd1 << 23)) >> 24;
      if (mag > slh_pkg::LEN_MAX) begin
        mag = slh_pkg::LEN_MAX;
      end
    end
    r.len = mag[LEN_W-1:0];
    r.heading = head[HEAD_W-1:0];
    return r;
  endfunction

  task automatic add_row(input logic [31:0] sx, input logic [31:0] sy,
                         input logic [31:0] ex, input logic [31:0] ey, input bit coincide);
    stim_row_t row;
    row.word = {ey, ex, sy, sx};
    row.want = coincide ? POINT_RESULT : predict_segment(row.word);
    directed_q.push_back(row);
  endtask

  task automatic offer_word(input logic [slh_pkg::IN_DATA_W-1:0] w, input seg_result_t want);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    offer_want <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    seg_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        heading_len_q.push_back(offer_want);
      end
      if (out_tvalid && out_tready) begin
        if (heading_len_q.size() == 0) begin
          flag_mismatch("unexpected word", out_tdata, 0);
        end else begin
          want = heading_len_q.pop_front();
          if (out_tdata[LEN_W-1:0] !== want.len) begin
            flag_mismatch("seg_length", out_tdata[LEN_W-1:0], want.len);
          end
          if (out_tdata[LEN_W +: HEAD_W] !== want.heading) begin
            flag_mismatch("heading_deg", out_tdata[LEN_W +: HEAD_W], want.heading);
          end
          if (out_tuser !== want.zero) begin
            flag_mismatch("zero_length", out_tuser, want.zero);
          end
          if (out_tdata[slh_pkg::OUT_DATA_W-1:LEN_W+HEAD_W] !== '0) begin
            flag_mismatch("pad bits", out_tdata[slh_pkg::OUT_DATA_W-1:LEN_W+HEAD_W], 0);
          end
        end
      end
    end
  end

  initial begin
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else if (!held && sent >= 300) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (80) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    stim_row_t row;
    logic [31:0] sx, sy, ex, ey, d;
    logic [slh_pkg::IN_DATA_W-1:0] w;
    seg_shape_t shape;
    for (int i = 0; i < 32; i++) atan_deg[i] = arctan_deg_q32(i);

    add_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    add_row(32'h1234_5678, 32'h9abc_def0, 32'h1234_5678, 32'h9abc_def0, 1'b1);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b0);
    add_row(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    add_row(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    add_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 1'b0);
    add_row(32'h0000_0000, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 1'b0);
    add_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b0);
    add_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hffff_ffff, 1'b0);
    add_row(32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
    add_row(32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff, 32'h0000_0001, 1'b0);
    add_row(32'h8000_0000, 32'h0000_0000, 32'h7fff_ffff, 32'h0000_0000, 1'b0);
    add_row(32'h7fff_ffff, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 1'b0);
    add_row(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h7fff_ffff, 1'b0);
    add_row(32'h0000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h8000_0000, 1'b0);
    add_row(32'h0000_0001, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b0);
    add_row(32'h0001_8000, 32'hfffe_8000, 32'hffff_0000, 32'h0002_0000, 1'b0);
    add_row(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
    add_row(32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa, 1'b0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_q[i]) begin
      row = directed_q[i];
      offer_word(row.word, row.want);
    end

    for (int n = 0; n < 1000; n++) begin
      calm = (n >= 850);
      sx = $urandom;
      sy = $urandom;
      ex = $urandom;
      ey = $urandom;
      shape = seg_shape_t'($urandom_range(0, 5));
      case (shape)
        SHAPE_SHORT: begin
          ex = sx + 32'($urandom_range(0, 2048)) - 32'd1024;
          ey = sy + 32'($urandom_range(0, 2048)) - 32'd1024;
        end
        SHAPE_POINT: begin
          ex = sx;
          ey = sy;
        end
        SHAPE_AXIS: begin
          if ($urandom_range(0, 1)) begin
            ex = sx;
          end else begin
            ey = sy;
          end
        end
        SHAPE_SCALED: begin
          d = $urandom >> $urandom_range(0, 31);
          ex = $urandom_range(0, 1) ? sx + d : sx - d;
          d = $urandom >> $urandom_range(0, 31);
          ey = $urandom_range(0, 1) ? sy + d : sy - d;
        end
        SHAPE_CORNER: begin
          sx = corner_vals[$urandom_range(0, 5)];
          sy = corner_vals[$urandom_range(0, 5)];
          ex = corner_vals[$urandom_range(0, 5)];
          ey = corner_vals[$urandom_range(0, 5)];
        end
        default: begin
        end
      endcase
      w = {ey, ex, sy, sx};
      offer_word(w, predict_segment(w));
    end

    in_tvalid <= 1'b0;
    while (heading_len_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/slh_pkg.sv
hw/rtl/slh_prep.sv
hw/rtl/slh_cell.sv
hw/rtl/slh_post.sv
hw/rtl/segment_length_and_heading_unit.sv
test/tb_segment_length_and_heading_unit.sv
